// ===== rtl/core/wis_pkg.sv =====
`timescale 1ns / 1ps
// Windowed information sum: shared types, constants and sequencer states.
// No dependencies; imported by every module of the block.
package wis_pkg;

   // Fixed-point format and datapath widths
   localparam int FRAC_BITS     = 16;
   localparam int ACC_W         = 48;                    // accumulator, signed
   localparam int TERM_W        = ACC_W;                 // quotient bits below the cap
   localparam int SUM_W         = TERM_W + 2;            // signed add of capped term
   localparam int MAG_W         = 63;                    // |S2*S0 - S1*S1|
   localparam int DEN_W         = 62;                    // S0*S0
   localparam int DIV_SHIFT     = TERM_W - FRAC_BITS;    // dividend bits preloaded
   localparam int DIV_CNT_W     = $clog2(TERM_W);
   localparam int MAX_LANDMARKS = 1024;
   localparam int LM_W          = $clog2(MAX_LANDMARKS);
   localparam int TIME_W        = 31;

   // CSR map: word index taken from paddr[CSR_ADDR_W-1:2]
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-3:0] REG_WINDOW_WIDTH = 1'b0;

   typedef struct packed {
      logic [30:0]        landmark_time;
      logic [30:0]        obs_time;
      logic               event_status;
      logic [30:0]        risk_sum;
      logic signed [31:0] first_moment;
      logic [30:0]        second_moment;
      logic [30:0]        penalty;
      logic               last_in_landmark;
   } wis_req_type;

   typedef struct packed {
      logic [9:0]         landmark_number;
      logic signed [47:0] neg_information;
      logic               saturated;
   } wis_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUB,
      ST_LOAD,
      ST_DIV,
      ST_ACC,
      ST_PEN,
      ST_EMIT
   } wis_state_type;

   // Controller -> datapath
   typedef struct packed {
      logic load_item;
      logic mul_en;
      logic sub_en;
      logic div_load;
      logic div_step;
      logic acc_term;
      logic acc_pen;
      logic emit;
   } wis_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic counts;     // item is an event inside the window
      logic cap;        // quotient would reach 2^TERM_W
      logic last;       // item closes its landmark
      logic out_free;   // result register can take a beat
   } wis_stat_type;

endpackage

// ===== rtl/core/wis_ctrl.sv =====
`timescale 1ns / 1ps
// Windowed information sum: sequencer for one item at a time.
// Depends on wis_pkg.
module wis_ctrl import wis_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  wis_stat_type stat,
   output wis_cmd_type  cmd
);

   wis_state_type        state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_SUB;
         end
         ST_SUB: begin
            cmd.sub_en = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = (stat.counts && !stat.cap) ? ST_DIV : ST_ACC;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(TERM_W - 1)) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.acc_term = 1'b1;
            state_in     = stat.last ? ST_PEN : ST_IDLE;
         end
         ST_PEN: begin
            cmd.acc_pen = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/wis_dp.sv =====
`timescale 1ns / 1ps
// Windowed information sum: products, restoring divider, saturating
// accumulator and result register. Depends on wis_pkg.
module wis_dp import wis_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  wis_cmd_type       cmd,
   output wis_stat_type      stat,
   input  wis_req_type       req_data,
   input  logic [TIME_W-1:0] window_width,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wis_rsp_type       rsp_data
);

   localparam logic signed [SUM_W-1:0] ACC_HI =
      {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] ACC_LO =
      {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

   // item and products
   wis_req_type       item_ff;
   logic [31:0]       s1mag_ff;
   logic [DEN_W-1:0]  p20_ff, den_ff;
   logic [MAG_W-1:0]  p11_ff, mag_ff;
   logic              counts_ff, neg_ff, cap_ff;

   // divider
   logic [DEN_W-1:0]  rem_ff;
   logic [TERM_W-1:0] dvd_ff, quo_ff;

   // accumulator and result
   logic signed [ACC_W-1:0] acc_ff;
   logic                    clip_ff;
   logic [LM_W-1:0]         lm_ff;
   logic                    rsp_valid_ff;
   wis_rsp_type             rsp_ff;

   logic [DEN_W-1:0]        rem_hi;
   logic                    cap_now;
   logic [DEN_W:0]          trial;
   logic                    trial_ge;
   logic [DEN_W:0]          trial_sub;
   logic [MAG_W-1:0]        diff_a, diff_b;
   logic [TERM_W:0]         tmag;
   logic signed [SUM_W-1:0] term, addend, sum, sum_sat;
   logic                    sum_clip;
   logic [31:0]             lt_plus_w;
   logic                    in_window;

   assign rem_hi  = DEN_W'(mag_ff >> DIV_SHIFT);
   assign cap_now = rem_hi >= den_ff;

   assign trial     = {rem_ff, dvd_ff[TERM_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign trial_ge  = trial >= {1'b0, den_ff};

   assign diff_a = {1'b0, p20_ff} - p11_ff;
   assign diff_b = p11_ff - {1'b0, p20_ff};

   assign lt_plus_w = {1'b0, item_ff.landmark_time} + {1'b0, window_width};
   assign in_window = (item_ff.landmark_time <= item_ff.obs_time) &&
                      ({1'b0, item_ff.obs_time} <= lt_plus_w);

   // capped term magnitude, zero when the item does not count
   always_comb begin
      if (!counts_ff) begin
         tmag = '0;
      end else if (cap_ff) begin
         tmag = {1'b1, {TERM_W{1'b0}}};
      end else begin
         tmag = {1'b0, quo_ff};
      end
      term     = neg_ff ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
      addend   = cmd.acc_pen ? $signed(SUM_W'(item_ff.penalty)) : term;
      sum      = $signed(SUM_W'(acc_ff)) + addend;
      sum_clip = 1'b0;
      sum_sat  = sum;
      if (sum > ACC_HI) begin
         sum_sat  = ACC_HI;
         sum_clip = 1'b1;
      end else if (sum < ACC_LO) begin
         sum_sat  = ACC_LO;
         sum_clip = 1'b1;
      end
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff  <= req_data;
         s1mag_ff <= req_data.first_moment[31] ? 32'(-req_data.first_moment)
                                               : 32'(req_data.first_moment);
      end
      if (cmd.mul_en) begin
         p20_ff    <= DEN_W'({31'd0, item_ff.second_moment} * {31'd0, item_ff.risk_sum});
         p11_ff    <= MAG_W'({32'd0, s1mag_ff} * {32'd0, s1mag_ff});
         den_ff    <= DEN_W'({31'd0, item_ff.risk_sum} * {31'd0, item_ff.risk_sum});
         counts_ff <= item_ff.event_status && (item_ff.risk_sum != '0) && in_window;
      end
      if (cmd.sub_en) begin
         neg_ff <= p11_ff > {1'b0, p20_ff};
         mag_ff <= (p11_ff > {1'b0, p20_ff}) ? diff_b : diff_a;
      end
      if (cmd.div_load) begin
         cap_ff <= cap_now;
         rem_ff <= rem_hi;
         dvd_ff <= {mag_ff[DIV_SHIFT-1:0], {FRAC_BITS{1'b0}}};
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
         dvd_ff <= {dvd_ff[TERM_W-2:0], 1'b0};
         quo_ff <= {quo_ff[TERM_W-2:0], trial_ge};
      end
      if (cmd.emit) begin
         rsp_ff.landmark_number <= 10'(lm_ff);
         rsp_ff.neg_information <= acc_ff;
         rsp_ff.saturated       <= clip_ff;
      end
   end

   // landmark state
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         clip_ff      <= 1'b0;
         lm_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.acc_term || cmd.acc_pen) begin
            acc_ff  <= ACC_W'(sum_sat);
            clip_ff <= clip_ff | sum_clip;
         end else if (cmd.emit) begin
            acc_ff  <= '0;
            clip_ff <= 1'b0;
            lm_ff   <= (lm_ff == LM_W'(MAX_LANDMARKS - 1)) ? '0 : lm_ff + 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.counts   = counts_ff;
   assign stat.cap      = cap_now;
   assign stat.last     = item_ff.last_in_landmark;
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/windowed_information_sum.sv =====
`timescale 1ns / 1ps
// Windowed information sum: top level with CSR block, sequencer and datapath.
// Depends on wis_pkg, wis_ctrl and wis_dp.
//
//   port group | direction | beat moves on
//   req_*      | in        | req_valid && !req_stall
//   rsp_*      | out       | rsp_valid && !rsp_stall
//   csr_*      | in/out    | psel && penable && pwrite (pready tied high)
//
// One item at a time. A counted event (event inside the window, S0 nonzero)
// whose quotient stays below the 2^48 cap goes from accept to the next accept
// through accept, multiply, subtract, divider load, 48 divider steps (one
// quotient bit per cycle), accumulate. Any other item, a capped term included,
// skips the divider steps. A last item adds penalty and result load, and waits
// in result load while the result register stays stalled with a prior beat.
// The result register lets the next item start while a total waits on rsp.
// Reset is synchronous and clears accumulator, clip flag, landmark counter,
// window width and all control state; no clearing pass.
module windowed_information_sum import wis_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  wis_req_type           req_data,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output wis_rsp_type           rsp_data,
   // APB CSR port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   wis_cmd_type       cmd;
   wis_stat_type      stat;
   logic [TIME_W-1:0] window_width_ff;
   logic              csr_hit;

   // register decode by word index; byte bits ignored
   assign csr_hit    = csr_paddr[CSR_ADDR_W-1:2] == REG_WINDOW_WIDTH;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? {1'b0, window_width_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_width_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         window_width_ff <= csr_pwdata[TIME_W-1:0];
      end
   end

   wis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   wis_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_data     (req_data),
      .window_width (window_width_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

   // sequencer issues at most one datapath step per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_item, cmd.mul_en, cmd.sub_en, cmd.div_load,
                cmd.div_step, cmd.acc_term, cmd.acc_pen, cmd.emit}))
      else $error("wis: more than one datapath command");

   // an accepted item blocks the request side on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("wis: request accepted while busy");

   // a loaded total is presented on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("wis: emitted total not presented");

   // no result beat out of reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("wis: result valid after reset");

endmodule

// ===== tb/wis_checker.sv =====
`timescale 1ns / 1ps
// Windowed information sum checker: tracks the window register, predicts each
// landmark total from accepted request beats and compares result beats in order.
// Depends on wis_pkg.
module wis_checker import wis_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  wis_req_type           req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  wis_rsp_type           rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output int                    open_totals,
   output int                    mismatch_count
);

   localparam logic signed [63:0] ACC_TOP    = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
   localparam logic signed [63:0] ACC_BOTTOM = -(64'sd1 <<< (ACC_W - 1));
   localparam logic [95:0]        TERM_LIMIT = 96'd1 << ACC_W;

   logic [30:0]        window;
   logic signed [63:0] info_acc;
   logic               clipped;
   int                 lm_index;
   wis_rsp_type        pending_totals[$];
   int                 errors = 0;

   assign mismatch_count = errors;

   task automatic flag_mismatch(input string msg);
      $display("[%0t] totals mismatch: %s", $time, msg);
      errors++;
   endtask

   // (S2*S0 - S1*S1) * 2^FRAC_BITS / (S0*S0), magnitude truncated and capped
   function automatic logic signed [63:0] info_term(input wis_req_type item);
      logic [31:0]        s1_mag;
      logic [63:0]        p20, p11, s0_sq, diff;
      logic [95:0]        quo;
      logic signed [63:0] mag;
      s1_mag = item.first_moment[31] ? -item.first_moment : item.first_moment;
      p20    = {33'd0, item.second_moment} * {33'd0, item.risk_sum};
      p11    = {32'd0, s1_mag} * {32'd0, s1_mag};
      s0_sq  = {33'd0, item.risk_sum} * {33'd0, item.risk_sum};
      diff   = (p11 > p20) ? p11 - p20 : p20 - p11;
      quo    = ({32'd0, diff} << FRAC_BITS) / {32'd0, s0_sq};
      if (quo > TERM_LIMIT) quo = TERM_LIMIT;
      mag = $signed(quo[63:0]);
      return (p11 > p20) ? -mag : mag;
   endfunction

   task automatic add_clamped(input logic signed [63:0] amount);
      logic signed [63:0] sum;
      sum = info_acc + amount;
      if (sum > ACC_TOP) begin
         sum     = ACC_TOP;
         clipped = 1'b1;
      end
      if (sum < ACC_BOTTOM) begin
         sum     = ACC_BOTTOM;
         clipped = 1'b1;
      end
      info_acc = sum;
   endtask

   task automatic absorb_item(input wis_req_type item);
      wis_rsp_type total;
      logic [31:0] reach;
      reach = {1'b0, item.landmark_time} + {1'b0, window};
      if (item.event_status && item.risk_sum != '0 &&
          item.landmark_time <= item.obs_time && {1'b0, item.obs_time} <= reach)
         add_clamped(info_term(item));
      if (item.last_in_landmark) begin
         add_clamped($signed({33'd0, item.penalty}));
         total.landmark_number = lm_index[9:0];
         total.neg_information = info_acc[47:0];
         total.saturated       = clipped;
         pending_totals.push_back(total);
         info_acc = '0;
         clipped  = 1'b0;
         lm_index = (lm_index + 1) % MAX_LANDMARKS;
      end
   endtask

   always @(posedge clock) begin : watch
      wis_rsp_type got, want;
      if (reset) begin
         window   = '0;
         info_acc = '0;
         clipped  = 1'b0;
         lm_index = 0;
         pending_totals.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == REG_WINDOW_WIDTH)
            window = csr_pwdata[30:0];
         // pop before push: a beat leaving now belongs to an older item
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (pending_totals.size() == 0) begin
               flag_mismatch($sformatf("unexpected beat lm %0d info %0d sat %0b",
                  got.landmark_number, got.neg_information, got.saturated));
            end else begin
               want = pending_totals.pop_front();
               if (got.landmark_number !== want.landmark_number)
                  flag_mismatch($sformatf("landmark_number got %0d want %0d",
                     got.landmark_number, want.landmark_number));
               if (got.neg_information !== want.neg_information)
                  flag_mismatch($sformatf("lm %0d neg_information got %0d want %0d",
                     want.landmark_number, got.neg_information, want.neg_information));
               if (got.saturated !== want.saturated)
                  flag_mismatch($sformatf("lm %0d saturated got %0b want %0b",
                     want.landmark_number, got.saturated, want.saturated));
            end
         end
         if (req_valid && !req_stall) absorb_item(req_data);
      end
      open_totals <= pending_totals.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Windowed information sum testbench top: clock, reset, request and CSR stimulus,
// random result-side stall, and the verdict. Depends on wis_pkg, wis_checker and
// windowed_information_sum.
module tb;
   import wis_pkg::*;

   // Settling allowance: a counted event plus the extra steps of a last item, rounded up.
   localparam int ITEM_CYCLES  = 60;
   localparam int RANDOM_ITEMS = 600;
   // Short run of single-item landmarks sent with no sender gaps.
   localparam int BURST_ITEMS  = 40;
   localparam int CYCLE_LIMIT  = 600000;
   localparam logic [CSR_ADDR_W-3:0] REG_SPARE = 1'b1;   // unmapped word
   localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   wis_req_type           req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   wis_rsp_type           rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   logic        calm    = 1'b0;   // last part of the run: no idling on either side
   logic        gaps_on = 1'b1;   // sender gaps allowed in the current stretch
   logic [30:0] window_now;       // window in force, for shaping observation times
   int          open_totals;
   int          mismatch_count;
   int          random_sent = 0;
   int          rsp_hold    = 0;
   int          cycles      = 0;

   always #5 clock = ~clock;

   windowed_information_sum u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   wis_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .open_totals    (open_totals),
      .mismatch_count (mismatch_count)
   );

   // Result-side stall: short stall bursts between free runs, some
   // of them long, so stalls land on every phase of the sequencer.
   always @(posedge clock) begin
      if (calm) begin
         rsp_stall <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (!rsp_stall && $urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         rsp_hold  <= $urandom_range(0, 12);
      end else begin
         rsp_stall <= 1'b0;
         rsp_hold  <= ($urandom_range(0, 2) == 0) ? $urandom_range(60, 300)
                                                  : $urandom_range(0, 30);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("windowed_information_sum verification failed");
         $finish;
      end
   end

   // Random magnitude anywhere from 1 bit to the full 31 bits
   function automatic logic [30:0] rand31();
      return 31'($urandom) >> $urandom_range(0, 30);
   endfunction

   // Signed S1 of random magnitude, both signs, the full width now and then
   function automatic logic signed [31:0] rand_s1();
      return $signed(32'($urandom)) >>> $urandom_range(0, 31);
   endfunction

   function automatic wis_req_type pack_item(input logic [30:0] lt, input logic [30:0] ot,
         input logic st, input logic [30:0] s0, input logic signed [31:0] s1,
         input logic [30:0] s2, input logic [30:0] pen, input logic last);
      wis_req_type item;
      item.landmark_time    = lt;
      item.obs_time         = ot;
      item.event_status     = st;
      item.risk_sum         = s0;
      item.first_moment     = s1;
      item.second_moment    = s2;
      item.penalty          = pen;
      item.last_in_landmark = last;
      return item;
   endfunction

   // Present one beat and hold it until accepted; the caller either sends the
   // next beat in the same step or a gap/drain lowers valid.
   task automatic send_beat(input wis_req_type item);
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Stop sending until every expected total has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_totals != 0) @(posedge clock);
   endtask

   // APB write with setup and access phases; the register takes the data on the access edge
   task automatic csr_write(input logic [CSR_ADDR_W-3:0] idx, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Window changes only with the block idle: no total outstanding, and any
   // non-last item still in the divider given time to finish.
   task automatic set_window(input logic [31:0] value);
      drain();
      repeat (ITEM_CYCLES) @(posedge clock);
      csr_write(REG_WINDOW_WIDTH, value);
      window_now = value[30:0];
   endtask

   // One landmark as the block expects it: shared landmark time, ascending
   // observation times clustered on and around the window edges, plausible
   // risk sums, last flag on the final beat only.
   task automatic send_formed_landmark();
      logic [30:0]        lt, s0, s1_mag, pen, tmp;
      logic signed [31:0] s1;
      logic [31:0]        reach, hi;
      logic [30:0]        times [0:7];
      int                 n, i, j;
      lt    = 31'($urandom) >> $urandom_range(0, 8);
      reach = {1'b0, lt} + {1'b0, window_now};
      hi    = (reach > {1'b0, TIME_MAX}) ? {1'b0, TIME_MAX} : reach;
      n     = $urandom_range(1, 8);
      for (i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0:       times[i] = lt;
            1:       times[i] = hi[30:0];
            2:       times[i] = (lt != '0) ? lt - 31'd1 : lt;
            3:       times[i] = (hi[30:0] != TIME_MAX) ? hi[30:0] + 31'd1 : hi[30:0];
            default: times[i] = 31'($urandom_range(lt, hi));
         endcase
      end
      // insertion sort: observations arrive in ascending time
      for (i = 1; i < n; i++) begin
         tmp = times[i];
         j   = i - 1;
         while (j >= 0 && times[j] > tmp) begin
            times[j + 1] = times[j];
            j--;
         end
         times[j + 1] = tmp;
      end
      for (i = 0; i < n; i++) begin
         s0     = 31'($urandom_range(32'h0000_1000, 32'h0400_0000));
         s1_mag = 31'($urandom_range(0, s0));
         s1     = $urandom_range(0, 1) ? -$signed({1'b0, s1_mag}) : $signed({1'b0, s1_mag});
         if (i == n - 1 && $urandom_range(0, 5) != 0)
            pen = 31'($urandom_range(0, 32'h0010_0000));
         else
            pen = rand31();
         send_beat(pack_item(lt, times[i], $urandom_range(0, 3) != 0, s0, s1, rand31(),
                             pen, i == n - 1));
         random_sent++;
      end
   endtask

   // Noise: unrelated beats with fully random fields, zero risk sums included,
   // last flag at random so landmarks merge or close early.
   task automatic send_noise();
      logic [30:0] s0;
      int          k;
      for (k = $urandom_range(1, 3); k > 0; k--) begin
         s0 = ($urandom_range(0, 7) == 0) ? '0 : rand31();
         send_beat(pack_item(31'($urandom), 31'($urandom), 1'($urandom_range(0, 1)), s0,
                             rand_s1(), rand31(), rand31(), $urandom_range(0, 2) == 0));
         random_sent++;
      end
   endtask

   initial begin : stimulus
      logic [31:0] w;
      int          phase, i;
      window_now = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- window at its reset value of zero ----
      // only obs_time == landmark_time counts; one tick later is outside
      send_beat(pack_item(31'h0064_0000, 31'h0064_0000, 1'b1, 31'h0001_0000, 32'sd0,
                          31'h0002_0000, 31'd0, 1'b0));
      send_beat(pack_item(31'h0064_0000, 31'h0064_0001, 1'b1, 31'h0001_0000, 32'sd0,
                          31'h0002_0000, TIME_MAX, 1'b1));
      // all-zero statistics, smallest risk sum
      send_beat(pack_item(31'd0, 31'd0, 1'b1, 31'd1, 32'sd0, 31'd0, 31'd0, 1'b1));

      // unmapped register must be ignored; bit 31 of the window write dropped
      drain();
      repeat (ITEM_CYCLES) @(posedge clock);
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      set_window(32'hFFFF_FFFF);

      // ---- widest window ----
      // S0 = 1 with S1 at its most negative: term hits the cap, sum clips low
      send_beat(pack_item(31'd0, TIME_MAX, 1'b1, 31'd1, 32'sh8000_0000, 31'd0, 31'd0, 1'b0));
      // obs_time below landmark_time adds nothing; total stays clipped
      send_beat(pack_item(TIME_MAX, TIME_MAX - 31'd1, 1'b1, TIME_MAX, 32'sh7FFF_FFFF,
                          TIME_MAX, 31'd0, 1'b1));
      // two near-2^47 terms overflow high, then a censored item with max penalty
      send_beat(pack_item(31'd5, TIME_MAX, 1'b1, 31'd1, 32'sd0, TIME_MAX, 31'd0, 1'b0));
      send_beat(pack_item(31'd5, TIME_MAX, 1'b1, 31'd1, 32'sd0, TIME_MAX, 31'd0, 1'b0));
      send_beat(pack_item(31'd5, TIME_MAX, 1'b0, TIME_MAX, 32'sd0, TIME_MAX, TIME_MAX, 1'b1));
      // zero risk sum is skipped; equal maxima give an exactly zero term
      send_beat(pack_item(31'd0, 31'd9, 1'b1, 31'd0, 32'sh7FFF_FFFF, TIME_MAX, 31'd0, 1'b0));
      send_beat(pack_item(31'd0, 31'd9, 1'b1, TIME_MAX, 32'sh7FFF_FFFF, TIME_MAX, 31'd0,
                          1'b0));
      // negative numerator: magnitude truncates toward zero, for both signs of S1
      send_beat(pack_item(31'd0, 31'd10, 1'b1, 31'd3, 32'sd2, 31'd1, 31'd0, 1'b0));
      send_beat(pack_item(31'd0, 31'd10, 1'b1, 31'd3, -32'sd2, 31'd1, 31'd0, 1'b1));

      // ---- window of 1.0 ----
      set_window(32'h0001_0000);
      // window end past the largest time, exact window end, one tick beyond
      send_beat(pack_item(31'h7FFF_0000, TIME_MAX, 1'b1, 31'h0001_0000, -32'sh0000_8000,
                          31'h0001_0000, 31'd0, 1'b0));
      send_beat(pack_item(31'h0001_0000, 31'h0002_0000, 1'b1, 31'h0002_0000,
                          32'sh0001_0000, 31'h0003_0000, 31'd0, 1'b0));
      send_beat(pack_item(31'h0001_0000, 31'h0002_0001, 1'b1, 31'h0002_0000,
                          32'sh0001_0000, 31'h0003_0000, 31'h0000_0100, 1'b1));

      // ---- back-to-back censored single-item landmarks ----
      gaps_on = 1'b0;
      for (i = 0; i < BURST_ITEMS; i++)
         send_beat(pack_item(rand31(), rand31(), 1'b0, rand31(), rand_s1(), rand31(),
                             31'($urandom_range(0, 255)), 1'b1));

      // ---- random landmarks over several window settings ----
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       w = $urandom_range(0, 32'h0004_0000);
            1:       w = $urandom;
            2:       w = 32'h0000_0000;
            default: w = {1'($urandom_range(0, 1)), TIME_MAX};
         endcase
         set_window(w);
         while (random_sent < (phase + 1) * RANDOM_ITEMS / 4) begin
            if (random_sent >= RANDOM_ITEMS - 50) calm <= 1'b1;
            if ($urandom_range(0, 4) == 0) gaps_on = !gaps_on;
            // occasionally hold off until the block has handed back everything
            if (random_sent < RANDOM_ITEMS - 50 && $urandom_range(0, 29) == 0) drain();
            if ($urandom_range(0, 4) == 0)
               send_noise();
            else
               send_formed_landmark();
         end
      end

      drain();
      repeat (ITEM_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && open_totals == 0)
         $display("windowed_information_sum verification clean");
      else
         $display("windowed_information_sum verification failed");
      $finish;
   end

endmodule

// ===== windowed_information_sum.f =====
rtl/core/wis_pkg.sv
rtl/core/wis_ctrl.sv
rtl/core/wis_dp.sv
rtl/core/windowed_information_sum.sv
tb/wis_checker.sv
tb/tb.sv
